// ===== sv/asl_pkg.sv =====
// shared types and constants for the assembly source lexer
package asl_pkg;

  // lexer modes, one-hot
  typedef enum logic [8:0] {
    M_IDLE    = 9'b000000001,
    M_COMMENT = 9'b000000010,
    M_WORD    = 9'b000000100,
    M_STR     = 9'b000001000,
    M_ESC     = 9'b000010000,
    M_HEX     = 9'b000100000,
    M_OCT     = 9'b001000000,
    M_LT      = 9'b010000000,
    M_GT      = 9'b100000000
  } asl_mode_e;

  // result kinds
  localparam logic [2:0] K_WBYTE = 3'd0;
  localparam logic [2:0] K_SBYTE = 3'd1;
  localparam logic [2:0] K_WEND  = 3'd2;
  localparam logic [2:0] K_SEND  = 3'd3;
  localparam logic [2:0] K_CHAR  = 3'd4;
  localparam logic [2:0] K_END   = 3'd5;

  // symbol values for merged shift tokens
  localparam logic [8:0] VAL_SHL = 9'd256;
  localparam logic [8:0] VAL_SHR = 9'd257;

  // configuration register indexes
  localparam int unsigned  CFG_IDX_BITS     = 1;
  localparam logic [0:0]   REG_COMMENT_CHAR = 1'd0;
  localparam logic [0:0]   REG_START_LINE   = 1'd1;
  localparam int unsigned  CFG_DATA_BITS    = 24;
  localparam int unsigned  OUT_LINE_BITS    = 24;
  localparam logic [8:0]   COMMENT_NONE     = 9'd256;

  // characters of interest
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LF_E   = 8'h66;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LT_E   = 8'h74;
  localparam logic [7:0] CH_LV     = 8'h76;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_UZ     = 8'h5A;

endpackage

// ===== sv/assembly_source_lexer_top.sv =====
// assembly source lexer: byte stream in, token result stream out
//
//  channel   | direction | request moves
//  s_axis    | in        | tdata: ch; tuser: end_of_input
//  m_axis    | out       | tdata: value, line; tuser: kind, token_start, string_error; tlast
//  cfg       | in        | one register write per cycle with cfg_we_i high
//
// an item is decoded in the cycle it is taken and its results (up to three) land in a
// three-entry result buffer; it sends one result per cycle while m_axis_tready is high.
// an item with several results holds the input side while the single output port
// drains the buffer.
// the input takes a new request in the cycle the last buffered result leaves.
// reset is asynchronous: idle mode, empty buffer, line count 1, no comment byte.
module assembly_source_lexer_top #(
  parameter int unsigned LINE_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // cfg write port
  input  logic                                 cfg_we_i,
  input  logic [asl_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [asl_pkg::CFG_DATA_BITS-1:0]    cfg_wdata_i,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [7:0]                           s_axis_tdata,  // [7:0] ch
  input  logic [0:0]                           s_axis_tuser,  // [0] end_of_input
  // result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [39:0]                          m_axis_tdata,  // [8:0] value, [32:9] line
  output logic [4:0]                           m_axis_tuser,  // [2:0] kind, [3] token_start,
                                                              // [4] string_error
  output logic                                 m_axis_tlast
);

  localparam int unsigned NRES = 3;
  localparam int unsigned OUT_LINE_BITS_C = asl_pkg::OUT_LINE_BITS;

  // character classes
  function automatic logic is_ident(input logic [7:0] c);
    return (c >= asl_pkg::CH_LA && c <= asl_pkg::CH_LZ) ||
           (c >= asl_pkg::CH_UA && c <= asl_pkg::CH_UZ) ||
           (c >= asl_pkg::CH_0 && c <= asl_pkg::CH_9) ||
           c == asl_pkg::CH_DOT || c == asl_pkg::CH_UNDER;
  endfunction

  // {valid, digit}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= asl_pkg::CH_0 && c <= asl_pkg::CH_9) begin
      d = c - asl_pkg::CH_0;
      return {1'b1, d[3:0]};
    end else if (c >= asl_pkg::CH_LA && c <= asl_pkg::CH_LF_E) begin
      d = c - asl_pkg::CH_LA + 8'd10;
      return {1'b1, d[3:0]};
    end else if (c >= asl_pkg::CH_UA && c <= asl_pkg::CH_UF) begin
      d = c - asl_pkg::CH_UA + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  // named escapes
  function automatic logic [7:0] esc_map(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    case (c)
      asl_pkg::CH_LA:   r = 8'd7;
      asl_pkg::CH_LB:   r = 8'd8;
      asl_pkg::CH_LF_E: r = 8'd12;
      asl_pkg::CH_LN:   r = 8'd10;
      asl_pkg::CH_LR:   r = 8'd13;
      asl_pkg::CH_LT_E: r = 8'd9;
      asl_pkg::CH_LV:   r = 8'd11;
      default:          r = c;
    endcase
    return r;
  endfunction

  // state
  asl_pkg::asl_mode_e     mode_q, mode_d;
  logic [7:0]             quote_q, quote_d;
  logic [11:0]            esc_q, esc_d;
  logic [1:0]             dcnt_q, dcnt_d;
  logic                   fresh_q, fresh_d;
  logic [LINE_BITS-1:0]   lc_q, lc_step;
  logic                   nl_q;
  logic [8:0]             comment_q;

  // result buffer
  logic [2:0]             rkind_q [NRES];
  logic [8:0]             rval_q  [NRES];
  logic                   rstart_q[NRES];
  logic                   rerr_q  [NRES];
  logic [OUT_LINE_BITS_C-1:0] rline_q;
  logic [1:0]             cnt_q, rd_q;

  // next-result values
  logic [2:0]             rkind_d [NRES];
  logic [8:0]             rval_d  [NRES];
  logic                   rstart_d[NRES];
  logic                   rerr_d  [NRES];
  logic [1:0]             n_res;

  logic                   go, emit, ee, es;
  logic [2:0]             ek;
  logic [8:0]             ev;
  logic [4:0]             hd;
  logic                   dig_ok;
  logic [3:0]             dig;
  logic [11:0]            esc_sh;
  logic [1:0]             dcnt_inc;
  logic [7:0]             sym;

  logic [7:0]             c;
  logic                   eoi;
  logic                   in_fire, out_fire, last_out;
  logic [LINE_BITS+OUT_LINE_BITS_C-1:0] line_wide, start_wide;

  assign c   = s_axis_tdata;
  assign eoi = s_axis_tuser[0];

  // handshake
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign last_out      = ((rd_q + 2'd1) == cnt_q);
  assign s_axis_tready = !m_axis_tvalid || (m_axis_tready && last_out);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_axis_tvalid && m_axis_tready;

  // line number for this item
  assign lc_step = (nl_q && lc_q != {LINE_BITS{1'b1}}) ? lc_q + 1'b1 : lc_q;
  assign line_wide  = {{OUT_LINE_BITS_C{1'b0}}, lc_step};
  assign start_wide = {{LINE_BITS{1'b0}}, cfg_wdata_i};

  // decode one item: up to three passes over the mode, one result at most per pass
  always_comb begin
    mode_d  = mode_q;
    quote_d = quote_q;
    esc_d   = esc_q;
    dcnt_d  = dcnt_q;
    fresh_d = fresh_q;
    n_res   = 2'd0;
    go      = 1'b1;
    emit    = 1'b0;
    ek      = asl_pkg::K_CHAR;
    ev      = 9'd0;
    es      = 1'b0;
    ee      = 1'b0;
    hd      = 5'd0;
    dig_ok  = 1'b0;
    dig     = 4'd0;
    esc_sh  = 12'd0;
    dcnt_inc = 2'd0;
    sym     = 8'd0;
    for (int k = 0; k < NRES; k++) begin
      rkind_d[k]  = asl_pkg::K_CHAR;
      rval_d[k]   = 9'd0;
      rstart_d[k] = 1'b0;
      rerr_d[k]   = 1'b0;
    end
    for (int i = 0; i < NRES; i++) begin
      emit = 1'b0;
      ek   = asl_pkg::K_CHAR;
      ev   = 9'd0;
      es   = 1'b0;
      ee   = 1'b0;
      if (go) begin
        go = 1'b0;
        if (eoi) begin
          // flush whatever is open, then the end result
          unique case (mode_d)
            asl_pkg::M_WORD: begin
              emit = 1'b1; ek = asl_pkg::K_WEND;
              mode_d = asl_pkg::M_IDLE; go = 1'b1;
            end
            asl_pkg::M_STR, asl_pkg::M_ESC: begin
              emit = 1'b1; ek = asl_pkg::K_SEND; es = fresh_d; ee = 1'b1;
              fresh_d = 1'b0; mode_d = asl_pkg::M_IDLE; go = 1'b1;
            end
            asl_pkg::M_HEX, asl_pkg::M_OCT: begin
              emit = 1'b1; ek = asl_pkg::K_SBYTE; ev = {1'b0, esc_d[7:0]}; es = fresh_d;
              fresh_d = 1'b0; mode_d = asl_pkg::M_STR; go = 1'b1;
            end
            asl_pkg::M_LT: begin
              emit = 1'b1; ev = {1'b0, asl_pkg::CH_LT};
              mode_d = asl_pkg::M_IDLE; go = 1'b1;
            end
            asl_pkg::M_GT: begin
              emit = 1'b1; ev = {1'b0, asl_pkg::CH_GT};
              mode_d = asl_pkg::M_IDLE; go = 1'b1;
            end
            default: begin
              emit = 1'b1; ek = asl_pkg::K_END;
              mode_d = asl_pkg::M_IDLE;
            end
          endcase
        end else begin
          unique case (mode_d)
            asl_pkg::M_COMMENT: begin
              if (c == asl_pkg::CH_LF) begin
                mode_d = asl_pkg::M_IDLE; go = 1'b1;
              end
            end
            asl_pkg::M_WORD: begin
              if (is_ident(c)) begin
                emit = 1'b1; ek = asl_pkg::K_WBYTE; ev = {1'b0, c};
              end else begin
                emit = 1'b1; ek = asl_pkg::K_WEND;
                mode_d = asl_pkg::M_IDLE; go = 1'b1;
              end
            end
            asl_pkg::M_STR: begin
              if (c == quote_d) begin
                emit = 1'b1; ek = asl_pkg::K_SEND; es = fresh_d;
                fresh_d = 1'b0; mode_d = asl_pkg::M_IDLE;
              end else if (c == asl_pkg::CH_LF) begin
                emit = 1'b1; ek = asl_pkg::K_SEND; es = fresh_d; ee = 1'b1;
                fresh_d = 1'b0; mode_d = asl_pkg::M_IDLE; go = 1'b1;
              end else if (c == asl_pkg::CH_BSLASH) begin
                mode_d = asl_pkg::M_ESC;
              end else begin
                emit = 1'b1; ek = asl_pkg::K_SBYTE; ev = {1'b0, c}; es = fresh_d;
                fresh_d = 1'b0;
              end
            end
            asl_pkg::M_ESC: begin
              if (c == asl_pkg::CH_LF) begin
                emit = 1'b1; ek = asl_pkg::K_SEND; es = fresh_d; ee = 1'b1;
                fresh_d = 1'b0; mode_d = asl_pkg::M_IDLE; go = 1'b1;
              end else if (c == asl_pkg::CH_X) begin
                esc_d = 12'd0; dcnt_d = 2'd0; mode_d = asl_pkg::M_HEX;
              end else if (c >= asl_pkg::CH_0 && c <= asl_pkg::CH_7) begin
                esc_d = {9'd0, c[2:0]}; dcnt_d = 2'd1; mode_d = asl_pkg::M_OCT;
              end else begin
                emit = 1'b1; ek = asl_pkg::K_SBYTE; ev = {1'b0, esc_map(c)}; es = fresh_d;
                fresh_d = 1'b0; mode_d = asl_pkg::M_STR;
              end
            end
            asl_pkg::M_HEX, asl_pkg::M_OCT: begin
              hd = hex_digit(c);
              if (mode_d == asl_pkg::M_HEX) begin
                dig_ok = hd[4];
                dig    = hd[3:0];
                esc_sh = {esc_d[7:0], 4'd0};
              end else begin
                dig_ok = (c >= asl_pkg::CH_0 && c <= asl_pkg::CH_7);
                dig    = {1'b0, c[2:0]};
                esc_sh = {esc_d[8:0], 3'd0};
              end
              if (!dig_ok) begin
                // digit run ended early: emit value and lex this byte as string text
                emit = 1'b1; ek = asl_pkg::K_SBYTE; ev = {1'b0, esc_d[7:0]}; es = fresh_d;
                fresh_d = 1'b0; mode_d = asl_pkg::M_STR; go = 1'b1;
              end else begin
                esc_d    = esc_sh + {8'd0, dig};
                dcnt_inc = dcnt_d + 2'd1;
                dcnt_d   = dcnt_inc;
                if (dcnt_inc == 2'd3) begin
                  emit = 1'b1; ek = asl_pkg::K_SBYTE; ev = {1'b0, esc_d[7:0]}; es = fresh_d;
                  fresh_d = 1'b0; mode_d = asl_pkg::M_STR;
                end
              end
            end
            asl_pkg::M_LT, asl_pkg::M_GT: begin
              sym    = (mode_d == asl_pkg::M_LT) ? asl_pkg::CH_LT : asl_pkg::CH_GT;
              mode_d = asl_pkg::M_IDLE;
              emit   = 1'b1;
              if (c == sym) begin
                ev = (sym == asl_pkg::CH_LT) ? asl_pkg::VAL_SHL : asl_pkg::VAL_SHR;
              end else begin
                ev = {1'b0, sym};
                go = 1'b1;
              end
            end
            default: begin
              mode_d = asl_pkg::M_IDLE;
              if (c != asl_pkg::CH_LF && {1'b0, c} == comment_q) begin
                mode_d = asl_pkg::M_COMMENT;
              end else if (c <= asl_pkg::CH_SPACE && c != asl_pkg::CH_LF) begin
                mode_d = asl_pkg::M_IDLE;
              end else if (is_ident(c)) begin
                emit = 1'b1; ek = asl_pkg::K_WBYTE; ev = {1'b0, c}; es = 1'b1;
                mode_d = asl_pkg::M_WORD;
              end else if (c == asl_pkg::CH_SQUOTE || c == asl_pkg::CH_DQUOTE) begin
                quote_d = c; fresh_d = 1'b1; mode_d = asl_pkg::M_STR;
              end else if (c == asl_pkg::CH_LT) begin
                mode_d = asl_pkg::M_LT;
              end else if (c == asl_pkg::CH_GT) begin
                mode_d = asl_pkg::M_GT;
              end else begin
                emit = 1'b1;
                ev = (c == asl_pkg::CH_LF) ? {1'b0, asl_pkg::CH_SEMI} : {1'b0, c};
              end
            end
          endcase
        end
        // store into the next free result slot
        if (emit && n_res < 2'd3) begin
          rkind_d[n_res]  = ek;
          rval_d[n_res]   = ev;
          rstart_d[n_res] = es;
          rerr_d[n_res]   = ee;
          n_res = n_res + 2'd1;
        end
      end
    end
  end

  // lexer state and config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= asl_pkg::M_IDLE;
      quote_q   <= 8'd0;
      esc_q     <= 12'd0;
      dcnt_q    <= 2'd0;
      fresh_q   <= 1'b0;
      lc_q      <= {{(LINE_BITS-1){1'b0}}, 1'b1};
      nl_q      <= 1'b0;
      comment_q <= asl_pkg::COMMENT_NONE;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        asl_pkg::REG_COMMENT_CHAR: comment_q <= cfg_wdata_i[8:0];
        asl_pkg::REG_START_LINE: begin
          lc_q <= start_wide[LINE_BITS-1:0];
          nl_q <= 1'b0;
        end
        default: ;
      endcase
    end else if (in_fire) begin
      mode_q  <= mode_d;
      quote_q <= quote_d;
      esc_q   <= esc_d;
      dcnt_q  <= dcnt_d;
      fresh_q <= fresh_d;
      lc_q    <= lc_step;
      nl_q    <= !eoi && c == asl_pkg::CH_LF;
    end
  end

  // result buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 2'd0;
    end else if (in_fire) begin
      cnt_q <= n_res;
      rd_q  <= 2'd0;
    end else if (out_fire) begin
      if (last_out) begin
        cnt_q <= 2'd0;
        rd_q  <= 2'd0;
      end else begin
        rd_q <= rd_q + 2'd1;
      end
    end
  end

  // result buffer payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int k = 0; k < NRES; k++) begin
        rkind_q[k]  <= rkind_d[k];
        rval_q[k]   <= rval_d[k];
        rstart_q[k] <= rstart_d[k];
        rerr_q[k]   <= rerr_d[k];
      end
      rline_q <= line_wide[OUT_LINE_BITS_C-1:0];
    end
  end

  // output mux
  assign m_axis_tdata = {7'd0, rline_q, rval_q[rd_q]};
  assign m_axis_tuser = {rerr_q[rd_q], rstart_q[rd_q], rkind_q[rd_q]};
  assign m_axis_tlast = last_out;

  // checks
  a_accept_only_on_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tready && m_axis_tvalid) |-> (m_axis_tready && m_axis_tlast))
    else $error("input taken while buffered results remain");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[2:0] == asl_pkg::K_END) |-> m_axis_tlast)
    else $error("end result not last of its item");

  a_start_kinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[3]) |->
      (m_axis_tuser[2:0] == asl_pkg::K_WBYTE || m_axis_tuser[2:0] == asl_pkg::K_SBYTE ||
       m_axis_tuser[2:0] == asl_pkg::K_SEND))
    else $error("token start on wrong kind");

  a_error_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[4]) |-> (m_axis_tuser[2:0] == asl_pkg::K_SEND))
    else $error("string error outside string end");

endmodule
